FILE: rtl/core/esig_pkg.sv
// ----------------------------------------------------------------------------
// esig_pkg
// Shared constants, codes, types and the fnv-1a byte step for the event
// stream signature block.
// ----------------------------------------------------------------------------
`default_nettype none

package esig_pkg;

  // default configuration of the kind table
  localparam int KIND_COUNT_DEF   = 12;
  localparam int CONTEXT_KIND_DEF = 11;

  // fnv-1a 64-bit constants
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  // words of the phantom context record
  localparam logic [31:0] PHANTOM_GAME_MODE = 32'h5048_414e;
  localparam logic [31:0] PHANTOM_LEVEL     = 32'h0054_4f4d;
  localparam logic [31:0] PHANTOM_OLD_MODE  = 32'h0000_0001;
  localparam logic [31:0] PHANTOM_OLD_LEVEL = 32'h0000_0000;

  // byte counts of the two record shapes
  localparam int BYTE_CNT_W = 5;
  localparam logic [BYTE_CNT_W-1:0] EVENT_BYTES = 5'd20;
  localparam logic [BYTE_CNT_W-1:0] TICK_BYTES  = 5'd12;
  localparam int REC_W = 160;

  // register indexes on the configuration port
  localparam logic [1:0] REG_HASH_ENABLE    = 2'd0;
  localparam logic [1:0] REG_PHANTOM_ENABLE = 2'd1;
  localparam logic [1:0] REG_PHANTOM_TICK   = 2'd2;

  typedef enum logic [1:0] {
    MODE_EVENT,
    MODE_CONTEXT,
    MODE_TICK,
    MODE_SUMMARY
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_EVENT,
    ST_TICK_SETUP,
    ST_MIX_TICK,
    ST_ROWS
  } seq_state_t;

  // controls for the hash unit
  typedef struct packed {
    logic mix;
    logic clear;
  } hash_ctl_t;

  // controls for the counter bank
  typedef struct packed {
    logic bump;    // count one event of the addressed kind
    logic fold;    // add the addressed tick count into its total and clear it
    logic finish;  // close the tick: totals and tick counter
  } cnt_ctl_t;

  // one fnv-1a byte step; the prime is 2^40 + 2^8 + 0xb3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x * 64'h0000_0000_0000_00b3);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/esig_hash.sv
// ----------------------------------------------------------------------------
// esig_hash
// Running fnv-1a hash register with one shared byte mixing step.
// ----------------------------------------------------------------------------
`default_nettype none

module esig_hash (
  input  logic                clk,
  input  logic                rst,
  input  esig_pkg::hash_ctl_t ctl,
  input  logic [7:0]          data_byte,
  output logic [63:0]         hash
);
  import esig_pkg::*;

  // one byte folded in per cycle while mix is set
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hash <= FNV_BASIS;
    end else if (ctl.mix) begin
      hash <= fnv_step(hash, data_byte);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/esig_counts.sv
// ----------------------------------------------------------------------------
// esig_counts
// Per-kind tick and total event counters, tick and summary totals.
// ----------------------------------------------------------------------------
`default_nettype none

module esig_counts #(
  parameter  int KIND_COUNT = esig_pkg::KIND_COUNT_DEF,
  localparam int IdxW       = $clog2(KIND_COUNT)
) (
  input  logic               clk,
  input  logic               rst,
  input  esig_pkg::cnt_ctl_t ctl,
  input  logic [IdxW-1:0]    addr,
  output logic [31:0]        tick_events,
  output logic [63:0]        total_events,
  output logic [63:0]        ticks_reported,
  output logic [31:0]        tick_kind_rd,
  output logic [63:0]        total_kind_rd
);
  import esig_pkg::*;

  logic [31:0] tick_kind  [KIND_COUNT];
  logic [63:0] total_kind [KIND_COUNT];

  // single read address shared by counting and reporting
  assign tick_kind_rd  = tick_kind[addr];
  assign total_kind_rd = total_kind[addr];

  // counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_events    <= '0;
      total_events   <= '0;
      ticks_reported <= '0;
      for (int i = 0; i < KIND_COUNT; i++) begin
        tick_kind[i]  <= '0;
        total_kind[i] <= '0;
      end
    end else begin
      if (ctl.bump) begin
        tick_events     <= tick_events + 32'd1;
        tick_kind[addr] <= tick_kind_rd + 32'd1;
      end
      if (ctl.fold) begin
        total_kind[addr] <= total_kind_rd + {32'd0, tick_kind_rd};
        tick_kind[addr]  <= '0;
      end
      if (ctl.finish) begin
        ticks_reported <= ticks_reported + 64'd1;
        total_events   <= total_events + {32'd0, tick_events};
        tick_events    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/esig_seq.sv
// ----------------------------------------------------------------------------
// esig_seq
// Sequencer: item decode, byte feed to the hash unit, row walk and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esig_seq #(
  parameter  int KIND_COUNT   = esig_pkg::KIND_COUNT_DEF,
  parameter  int CONTEXT_KIND = esig_pkg::CONTEXT_KIND_DEF,
  localparam int IdxW         = $clog2(KIND_COUNT)
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                hash_enable,
  input  logic                phantom_enable,
  input  logic [63:0]         phantom_tick,
  // input items
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          mode,
  input  logic [3:0]          event_kind,
  input  logic signed [31:0]  arg_a,
  input  logic signed [31:0]  arg_b,
  input  logic signed [31:0]  arg_c,
  input  logic signed [31:0]  arg_d,
  input  logic [63:0]         tick_number,
  // hash unit
  output esig_pkg::hash_ctl_t hash_ctl,
  output logic [7:0]          hash_byte,
  input  logic [63:0]         hash,
  // counter bank
  output esig_pkg::cnt_ctl_t  cnt_ctl,
  output logic [IdxW-1:0]     cnt_addr,
  input  logic [31:0]         tick_events,
  input  logic [63:0]         total_events,
  input  logic [63:0]         ticks_reported,
  input  logic [31:0]         tick_kind_rd,
  input  logic [63:0]         total_kind_rd,
  // results
  output logic                result_valid,
  input  logic                result_stall,
  output logic                report,
  output logic [63:0]         tick_or_ticks,
  output logic [63:0]         row_hash,
  output logic [63:0]         event_total,
  output logic [3:0]          kind_index,
  output logic [63:0]         kind_count,
  output logic                last
);
  import esig_pkg::*;

  localparam logic            CTX_OK    = (CONTEXT_KIND < KIND_COUNT);
  localparam logic [IdxW-1:0] CTX_IDX   = IdxW'(CONTEXT_KIND);
  localparam logic [31:0]     CTX_WORD  = 32'(CONTEXT_KIND);
  localparam logic [IdxW-1:0] FIRST_IDX = IdxW'(1);
  localparam logic [IdxW-1:0] LAST_IDX  = IdxW'(KIND_COUNT - 1);

  seq_state_t            state, state_next;
  logic [REC_W-1:0]      rec;
  logic [BYTE_CNT_W-1:0] byte_left;
  logic [IdxW-1:0]       ev_idx;
  logic [IdxW-1:0]       row_idx;
  logic                  report_sel;
  logic                  tick_pending;
  logic [63:0]           tick_reg;
  logic                  context_seen;
  logic [31:0]           prev_mode;
  logic [31:0]           prev_level;

  logic                  accept;
  logic                  kind_ok;
  logic                  ctx_change;
  logic                  phantom_hit;
  logic                  rec_load;
  logic [REC_W-1:0]      rec_value;
  logic [BYTE_CNT_W-1:0] bytes_value;
  logic [IdxW-1:0]       idx_value;
  logic                  ctx_update;
  logic                  pending_value;
  logic                  out_load;
  logic                  last_byte;

  // item decode
  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && (state == ST_IDLE);
  assign kind_ok     = (event_kind != 4'd0) && ({1'b0, event_kind} < 5'(KIND_COUNT));
  assign ctx_change  = !context_seen || ($unsigned(arg_a) != prev_mode)
                       || ($unsigned(arg_b) != prev_level);
  assign phantom_hit = phantom_enable && (tick_number == phantom_tick);
  assign last_byte   = (byte_left == BYTE_CNT_W'(1));
  assign hash_byte   = rec[7:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next    = state;
    hash_ctl      = '0;
    cnt_ctl       = '0;
    cnt_addr      = ev_idx;
    rec_load      = 1'b0;
    rec_value     = '0;
    bytes_value   = EVENT_BYTES;
    idx_value     = ev_idx;
    ctx_update    = 1'b0;
    pending_value = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && hash_enable) begin
          unique case (mode_t'(mode))
            MODE_EVENT: begin
              if (kind_ok) begin
                rec_load   = 1'b1;
                rec_value  = {$unsigned(arg_d), $unsigned(arg_c), $unsigned(arg_b),
                              $unsigned(arg_a), 28'd0, event_kind};
                idx_value  = event_kind[IdxW-1:0];
                state_next = ST_MIX_EVENT;
              end
            end
            MODE_CONTEXT: begin
              if (ctx_change) begin
                ctx_update = 1'b1;
                if (CTX_OK) begin
                  rec_load   = 1'b1;
                  rec_value  = {(context_seen ? prev_level : 32'hffff_ffff),
                                (context_seen ? prev_mode : 32'hffff_ffff),
                                $unsigned(arg_b), $unsigned(arg_a), CTX_WORD};
                  idx_value  = CTX_IDX;
                  state_next = ST_MIX_EVENT;
                end
              end
            end
            MODE_TICK: begin
              if (phantom_hit && CTX_OK) begin
                rec_load      = 1'b1;
                rec_value     = {PHANTOM_OLD_LEVEL, PHANTOM_OLD_MODE, PHANTOM_LEVEL,
                                 PHANTOM_GAME_MODE, CTX_WORD};
                idx_value     = CTX_IDX;
                pending_value = 1'b1;
                state_next    = ST_MIX_EVENT;
              end else begin
                state_next = ST_TICK_SETUP;
              end
            end
            MODE_SUMMARY: begin
              state_next = ST_ROWS;
            end
          endcase
        end
      end
      ST_MIX_EVENT: begin
        hash_ctl.mix = 1'b1;
        if (last_byte) begin
          cnt_ctl.bump = 1'b1;
          state_next   = tick_pending ? ST_TICK_SETUP : ST_IDLE;
        end
      end
      ST_TICK_SETUP: begin
        rec_load    = 1'b1;
        rec_value   = {64'd0, tick_events, tick_reg[63:32], tick_reg[31:0]};
        bytes_value = TICK_BYTES;
        state_next  = ST_MIX_TICK;
      end
      ST_MIX_TICK: begin
        hash_ctl.mix = 1'b1;
        if (last_byte) begin
          state_next = ST_ROWS;
        end
      end
      ST_ROWS: begin
        cnt_addr = row_idx;
        if (!result_valid || !result_stall) begin
          out_load     = 1'b1;
          cnt_ctl.fold = !report_sel;
          if (row_idx == LAST_IDX) begin
            cnt_ctl.finish = !report_sel;
            hash_ctl.clear = !report_sel;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // record shifter and item registers
  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec       <= rec_value;
      byte_left <= bytes_value;
      ev_idx    <= idx_value;
    end else if (hash_ctl.mix) begin
      rec       <= rec >> 8;
      byte_left <= byte_left - BYTE_CNT_W'(1);
    end
    if (accept) begin
      tick_reg   <= tick_number;
      report_sel <= (mode_t'(mode) == MODE_SUMMARY);
      row_idx    <= FIRST_IDX;
    end else if (out_load) begin
      row_idx <= row_idx + FIRST_IDX;
    end
  end

  // context tracking and phantom flag
  always_ff @(posedge clk) begin
    if (rst) begin
      context_seen <= 1'b0;
      prev_mode    <= '0;
      prev_level   <= '0;
      tick_pending <= 1'b0;
    end else begin
      if (accept) begin
        tick_pending <= pending_value;
      end
      if (ctx_update) begin
        context_seen <= 1'b1;
        prev_mode    <= $unsigned(arg_a);
        prev_level   <= $unsigned(arg_b);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      report        <= report_sel;
      tick_or_ticks <= report_sel ? ticks_reported : tick_reg;
      row_hash      <= report_sel ? 64'd0 : hash;
      event_total   <= report_sel ? total_events : {32'd0, tick_events};
      kind_index    <= 4'(row_idx);
      kind_count    <= report_sel ? total_kind_rd : {32'd0, tick_kind_rd};
      last          <= (row_idx == LAST_IDX);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/event_stream_signature.sv
// ----------------------------------------------------------------------------
// event_stream_signature
// Per-tick fnv-1a 64-bit signature over typed event records, with per-kind
// event counts per tick and in total.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on item_valid / item_stall; mode selects an event
//   record, a context observation, a tick boundary or a summary request.
//   Results leave on result_valid / result_stall, KIND_COUNT-1 items per tick
//   or summary, with last set on the final one. Registers are written over
//   the apb port (hash_enable at 0x00, phantom_enable at 0x08, phantom_tick
//   at 0x10); the user must do so only while the block is idle, which the
//   block does not enforce. One shared byte step of the hash unit runs per
//   cycle, so cost is set by the bytes hashed: 20 for an event or context
//   item; an ignored item is taken without a stall. A tick first hashes the
//   20-byte phantom record if due, runs a setup step, hashes 12 bytes, then
//   gives one row per cycle; while result_stall is high the row walk waits
//   with the result held. A summary starts its rows in the cycle after
//   accept. item_stall is high from accept until the last byte of an event
//   or context record is hashed or the last row is in the result register.
//   Synchronous reset clears hash, counters, context state and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module event_stream_signature #(
  parameter  int KIND_COUNT   = esig_pkg::KIND_COUNT_DEF,
  parameter  int CONTEXT_KIND = esig_pkg::CONTEXT_KIND_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // input items
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         mode,
  input  logic [3:0]         event_kind,
  input  logic signed [31:0] arg_a,
  input  logic signed [31:0] arg_b,
  input  logic signed [31:0] arg_c,
  input  logic signed [31:0] arg_d,
  input  logic [63:0]        tick_number,
  // results
  output logic               result_valid,
  input  logic               result_stall,
  output logic               report,
  output logic [63:0]        tick_or_ticks,
  output logic [63:0]        row_hash,
  output logic [63:0]        event_total,
  output logic [3:0]         kind_index,
  output logic [63:0]        kind_count,
  output logic               last
);
  import esig_pkg::*;

  localparam int IdxW = $clog2(KIND_COUNT);

  logic            hash_enable;
  logic            phantom_enable;
  logic [63:0]     phantom_tick;
  logic            cfg_write;
  logic [1:0]      reg_sel;

  hash_ctl_t       hash_ctl;
  logic [7:0]      hash_byte;
  logic [63:0]     hash;
  cnt_ctl_t        cnt_ctl;
  logic [IdxW-1:0] cnt_addr;
  logic [31:0]     tick_events;
  logic [63:0]     total_events;
  logic [63:0]     ticks_reported;
  logic [31:0]     tick_kind_rd;
  logic [63:0]     total_kind_rd;

  // register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_enable    <= 1'b0;
      phantom_enable <= 1'b0;
      phantom_tick   <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_HASH_ENABLE:    hash_enable    <= pwdata[0];
        REG_PHANTOM_ENABLE: phantom_enable <= pwdata[0];
        REG_PHANTOM_TICK:   phantom_tick   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_HASH_ENABLE:    prdata = {63'd0, hash_enable};
      REG_PHANTOM_ENABLE: prdata = {63'd0, phantom_enable};
      REG_PHANTOM_TICK:   prdata = phantom_tick;
      default:            prdata = '0;
    endcase
  end

  esig_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .ctl       (hash_ctl),
    .data_byte (hash_byte),
    .hash      (hash)
  );

  esig_counts #(
    .KIND_COUNT (KIND_COUNT)
  ) u_counts (
    .clk            (clk),
    .rst            (rst),
    .ctl            (cnt_ctl),
    .addr           (cnt_addr),
    .tick_events    (tick_events),
    .total_events   (total_events),
    .ticks_reported (ticks_reported),
    .tick_kind_rd   (tick_kind_rd),
    .total_kind_rd  (total_kind_rd)
  );

  esig_seq #(
    .KIND_COUNT   (KIND_COUNT),
    .CONTEXT_KIND (CONTEXT_KIND)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .hash_enable    (hash_enable),
    .phantom_enable (phantom_enable),
    .phantom_tick   (phantom_tick),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .event_kind     (event_kind),
    .arg_a          (arg_a),
    .arg_b          (arg_b),
    .arg_c          (arg_c),
    .arg_d          (arg_d),
    .tick_number    (tick_number),
    .hash_ctl       (hash_ctl),
    .hash_byte      (hash_byte),
    .hash           (hash),
    .cnt_ctl        (cnt_ctl),
    .cnt_addr       (cnt_addr),
    .tick_events    (tick_events),
    .total_events   (total_events),
    .ticks_reported (ticks_reported),
    .tick_kind_rd   (tick_kind_rd),
    .total_kind_rd  (total_kind_rd),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .report         (report),
    .tick_or_ticks  (tick_or_ticks),
    .row_hash       (row_hash),
    .event_total    (event_total),
    .kind_index     (kind_index),
    .kind_count     (kind_count),
    .last           (last)
  );

endmodule

`default_nettype wire

FILE: rtl/core/esig_checker.sv
// ----------------------------------------------------------------------------
// esig_checker
// Port-level checks on the result channel of event_stream_signature.
// ----------------------------------------------------------------------------
`default_nettype none

module esig_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        report,
  input logic [63:0] row_hash,
  input logic [3:0]  kind_index,
  input logic        last
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(kind_index) && $stable(row_hash))
    else $error("stalled result changed");

  // rows never carry kind zero
  a_kind_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> kind_index != 4'd0)
    else $error("result with kind zero");

  // summary items carry no hash
  a_summary_hash: assert property (@(posedge clk) disable iff (rst)
    result_valid && report |-> row_hash == 64'd0)
    else $error("summary item with nonzero hash");

  // rows of one run follow each other with rising kind
  a_rows_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |=>
      result_valid && (kind_index == $past(kind_index) + 4'd1) && (report == $past(report)))
    else $error("gap or kind skip inside a row run");

endmodule

bind event_stream_signature esig_checker u_esig_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for event_stream_signature. A clocked driver feeds
// items from a queue, a clocked monitor checks every result row against a
// behavioral signature model updated at each accepted item, and registers
// are set over the apb port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import esig_pkg::*;

  localparam int KINDS          = KIND_COUNT_DEF;
  localparam int CTX_KIND       = CONTEXT_KIND_DEF;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 50;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    mode_t              op;
    logic [3:0]         kind;
    logic signed [31:0] a, b, c, d;
    logic [63:0]        tick;
  } item_t;

  typedef struct {
    logic        is_summary;
    logic [63:0] tick_val;
    logic [63:0] sig;
    logic [63:0] events;
    logic [3:0]  kind;
    logic [63:0] count;
    logic        is_last;
  } row_t;

  // dut connections, all inputs known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         mode = '0;
  logic [3:0]         event_kind = '0;
  logic signed [31:0] arg_a = '0;
  logic signed [31:0] arg_b = '0;
  logic signed [31:0] arg_c = '0;
  logic signed [31:0] arg_d = '0;
  logic [63:0]        tick_number = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               report;
  logic [63:0]        tick_or_ticks;
  logic [63:0]        row_hash;
  logic [63:0]        event_total;
  logic [3:0]         kind_index;
  logic [63:0]        kind_count;
  logic               last;

  event_stream_signature dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .event_kind(event_kind),
    .arg_a(arg_a), .arg_b(arg_b), .arg_c(arg_c), .arg_d(arg_d),
    .tick_number(tick_number),
    .result_valid(result_valid), .result_stall(result_stall),
    .report(report), .tick_or_ticks(tick_or_ticks), .row_hash(row_hash),
    .event_total(event_total), .kind_index(kind_index),
    .kind_count(kind_count), .last(last)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // testbench state
  item_t pending_items[$];
  row_t  expected_rows[$];
  item_t on_wire;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    gap_left = 0;
  int    stall_left = 0;
  int    mismatches = 0;
  int    items_taken = 0;
  int    rows_checked = 0;
  int    ticks_seen = 0;
  int    phantom_hits = 0;
  int    quiet_cycles = 0;

  // register copies
  logic        cfg_enable = 1'b0;
  logic        cfg_phantom = 1'b0;
  logic [63:0] cfg_phantom_tick = '0;

  // signature model state
  logic [63:0] sig_hash = FNV_BASIS;
  logic [31:0] tick_events = '0;
  logic [31:0] tick_kinds [0:15];
  logic [63:0] total_kinds [0:15];
  logic [63:0] all_events = '0;
  logic [63:0] ticks_done = '0;
  logic        ctx_seen = 1'b0;
  logic [31:0] prev_game = '0;
  logic [31:0] prev_level = '0;

  // generator memory for context items and tick numbers
  logic signed [31:0] gen_game = '0;
  logic signed [31:0] gen_level = '0;
  logic [63:0]        tick_seq = 64'd100;

  initial begin
    for (int k = 0; k < 16; k++) begin
      tick_kinds[k] = '0;
      total_kinds[k] = '0;
    end
  end

  // fnv-1a over the four bytes of a word, low byte first
  task automatic fold_word(input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++)
      sig_hash = (sig_hash ^ {56'd0, w[8*i +: 8]}) * FNV_PRIME;
  endtask

  // hash and count one record, dropping kinds outside the table
  task automatic log_record(input logic [3:0] kind, input logic [31:0] a,
                            input logic [31:0] b, input logic [31:0] c,
                            input logic [31:0] d);
    if (kind == 0 || kind >= KINDS)
      return;
    fold_word({28'd0, kind});
    fold_word(a);
    fold_word(b);
    fold_word(c);
    fold_word(d);
    tick_events++;
    tick_kinds[kind]++;
  endtask

  // update the signature model for one accepted item, queue its rows
  task automatic absorb_item(input item_t it);
    row_t row;
    int   k;
    if (!cfg_enable)
      return;
    case (it.op)
      MODE_EVENT: begin
        log_record(it.kind, it.a, it.b, it.c, it.d);
      end
      MODE_CONTEXT: begin
        if (!ctx_seen || it.a != prev_game || it.b != prev_level) begin
          log_record(4'(CTX_KIND), it.a, it.b,
                     ctx_seen ? prev_game : 32'hffff_ffff,
                     ctx_seen ? prev_level : 32'hffff_ffff);
          prev_game = it.a;
          prev_level = it.b;
          ctx_seen = 1'b1;
        end
      end
      MODE_TICK: begin
        if (cfg_phantom && it.tick == cfg_phantom_tick) begin
          log_record(4'(CTX_KIND), PHANTOM_GAME_MODE, PHANTOM_LEVEL,
                     PHANTOM_OLD_MODE, PHANTOM_OLD_LEVEL);
          phantom_hits++;
        end
        fold_word(it.tick[31:0]);
        fold_word(it.tick[63:32]);
        fold_word(tick_events);
        for (k = 1; k < KINDS; k++) begin
          row.is_summary = 1'b0;
          row.tick_val = it.tick;
          row.sig = sig_hash;
          row.events = {32'd0, tick_events};
          row.kind = 4'(k);
          row.count = {32'd0, tick_kinds[k]};
          row.is_last = (k + 1 >= KINDS);
          expected_rows.push_back(row);
        end
        ticks_done++;
        ticks_seen++;
        all_events += {32'd0, tick_events};
        for (k = 1; k < KINDS; k++)
          total_kinds[k] += {32'd0, tick_kinds[k]};
        for (k = 0; k < 16; k++)
          tick_kinds[k] = '0;
        sig_hash = FNV_BASIS;
        tick_events = '0;
      end
      default: begin
        for (k = 1; k < KINDS; k++) begin
          row.is_summary = 1'b1;
          row.tick_val = ticks_done;
          row.sig = '0;
          row.events = all_events;
          row.kind = 4'(k);
          row.count = total_kinds[k];
          row.is_last = (k + 1 >= KINDS);
          expected_rows.push_back(row);
        end
      end
    endcase
  endtask

  // print one mismatch line (up to a limit) and count it
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at row %0d: %s got %h want %h", rows_checked, what, got, want);
    mismatches++;
  endtask

  // item driver with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) begin
        absorb_item(on_wire);
        items_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_items.size() > 0 && idle_pct > 0 &&
                     $urandom_range(99) < idle_pct) begin
          gap_left = $urandom_range(9);
          item_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_wire = pending_items.pop_front();
          mode <= on_wire.op;
          event_kind <= on_wire.kind;
          arg_a <= on_wire.a;
          arg_b <= on_wire.b;
          arg_c <= on_wire.c;
          arg_d <= on_wire.d;
          tick_number <= on_wire.tick;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_rows.size() == 0) begin
          flag_mismatch("row with none pending, tick_or_ticks", tick_or_ticks, '0);
        end else begin
          row_t want;
          want = expected_rows.pop_front();
          if (report !== want.is_summary)
            flag_mismatch("report", {63'd0, report}, {63'd0, want.is_summary});
          if (tick_or_ticks !== want.tick_val)
            flag_mismatch("tick_or_ticks", tick_or_ticks, want.tick_val);
          if (row_hash !== want.sig)
            flag_mismatch("row_hash", row_hash, want.sig);
          if (event_total !== want.events)
            flag_mismatch("event_total", event_total, want.events);
          if (kind_index !== want.kind)
            flag_mismatch("kind_index", {60'd0, kind_index}, {60'd0, want.kind});
          if (kind_count !== want.count)
            flag_mismatch("kind_count", kind_count, want.count);
          if (last !== want.is_last)
            flag_mismatch("last", {63'd0, last}, {63'd0, want.is_last});
        end
        rows_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(9);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || psel || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d rows outstanding",
                 quiet_cycles, expected_rows.size());
        $display("event_stream_signature test failed");
        $finish;
      end
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HASH_ENABLE:    cfg_enable = value[0];
      REG_PHANTOM_ENABLE: cfg_phantom = value[0];
      REG_PHANTOM_TICK:   cfg_phantom_tick = value;
      default: ;
    endcase
  endtask

  // wait until every item is taken and every row has come back
  task automatic settle();
    wait (pending_items.size() == 0 && !item_valid && expected_rows.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic item_t mk(input mode_t op, input logic [3:0] kind,
                               input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [63:0] tick);
    item_t it;
    it.op = op;
    it.kind = kind;
    it.a = a;
    it.b = b;
    it.c = c;
    it.d = d;
    it.tick = tick;
    return it;
  endfunction

  // mostly valid events, context changes and ticks; some noise kinds
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    it = mk(MODE_EVENT, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
            {$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(7) != 0)
        it.kind = 4'($urandom_range(1, KINDS - 1));
    end else if (pick < 70) begin
      it.op = MODE_CONTEXT;
      case ($urandom_range(3))
        0: begin
          it.a = gen_game;
          it.b = gen_level;
        end
        1: begin
          it.a = gen_game;
          it.b = $urandom_range(3);
        end
        2: begin
          it.a = $urandom_range(3);
          it.b = gen_level;
        end
        default: ;
      endcase
      gen_game = it.a;
      gen_level = it.b;
    end else if (pick < 92) begin
      it.op = MODE_TICK;
      case ($urandom_range(3))
        0: it.tick = cfg_phantom_tick;
        1: begin
          tick_seq++;
          it.tick = tick_seq;
        end
        default: ;
      endcase
    end else begin
      it.op = MODE_SUMMARY;
    end
    return it;
  endfunction

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // hashing still off after reset: everything ignored
    idle_pct = 30;
    stall_pct = 30;
    repeat (6) pending_items.push_back(random_item());
    settle();

    write_reg(REG_HASH_ENABLE, 64'd1);
    write_reg(REG_PHANTOM_ENABLE, 64'd0);
    write_reg(REG_PHANTOM_TICK, 64'd0);
    write_reg(REG_UNUSED, '1);

    // directed: first context, repeats, kind edges, word extremes
    pending_items.push_back(mk(MODE_CONTEXT, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_CONTEXT, 4'd0, 32'd0, 32'd0, '1, '1, '1));
    pending_items.push_back(mk(MODE_EVENT, 4'd1, 32'd0, 32'd0, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_EVENT, 4'(KINDS - 1), '1, '1, '1, '1, '1));
    pending_items.push_back(mk(MODE_EVENT, 4'd0, 32'd7, 32'd8, 32'd9, 32'd10, '0));
    pending_items.push_back(mk(MODE_EVENT, 4'(KINDS), 32'd7, 32'd8, 32'd9, 32'd10, '0));
    pending_items.push_back(mk(MODE_EVENT, 4'd15, '1, '1, '1, '1, '1));
    pending_items.push_back(mk(MODE_EVENT, 4'd5, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 32'h7fff_ffff, '0));
    pending_items.push_back(mk(MODE_CONTEXT, 4'd0, 32'h8000_0000, 32'h7fff_ffff,
                               32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_CONTEXT, 4'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_CONTEXT, 4'd0, 32'd1, 32'd0, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0));
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '1));
    pending_items.push_back(mk(MODE_SUMMARY, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(MODE_EVENT, 4'd2, $urandom, $urandom, $urandom,
                               $urandom, '0));
    pending_items.push_back(mk(MODE_EVENT, 4'd3, $urandom, $urandom, $urandom,
                               $urandom, '0));
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                               64'h0000_0001_ffff_ffff));
    pending_items.push_back(mk(MODE_SUMMARY, 4'd0, '1, '1, '1, '1, '1));
    settle();

    // phantom on the all-ones tick, heavy idling on both sides
    write_reg(REG_PHANTOM_ENABLE, 64'd1);
    write_reg(REG_PHANTOM_TICK, '1);
    idle_pct = 50;
    stall_pct = 50;
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '1));
    pending_items.push_back(mk(MODE_EVENT, 4'd4, $urandom, $urandom, $urandom,
                               $urandom, '0));
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '1));
    pending_items.push_back(mk(MODE_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0));
    repeat (26) pending_items.push_back(random_item());
    settle();

    // phantom on tick zero, light idling
    write_reg(REG_PHANTOM_TICK, 64'd0);
    idle_pct = 15;
    stall_pct = 15;
    repeat (30) pending_items.push_back(random_item());
    settle();

    // hashing off again: items ignored, state kept
    write_reg(REG_HASH_ENABLE, 64'd0);
    repeat (5) pending_items.push_back(random_item());
    settle();

    // last part: random phantom tick, no idling at all
    write_reg(REG_HASH_ENABLE, 64'd1);
    write_reg(REG_PHANTOM_TICK, {$urandom, $urandom});
    idle_pct = 0;
    stall_pct = 0;
    repeat (24) pending_items.push_back(random_item());
    pending_items.push_back(mk(MODE_SUMMARY, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0, '0));
    settle();

    $display("covered %0d items, %0d rows checked, %0d ticks (%0d with phantom record)",
             items_taken, rows_checked, ticks_seen, phantom_hits);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_rows.size() == 0)
      $display("event_stream_signature test passed");
    else
      $display("event_stream_signature test failed");
    $finish;
  end

endmodule
